// File: rtl/config_line_lexer_defines.svh
// assertion macros for the config line lexer
`ifndef CONFIG_LINE_LEXER_DEFINES_SVH
`define CONFIG_LINE_LEXER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CLL_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define CLL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/cll_pkg.sv
// types and constants for the config line lexer
`default_nettype none
package cll_pkg;

	typedef enum logic [3:0] {
		ST_BAD_KEY = 4'd0,
		ST_BAD_VAL = 4'd1,
		ST_MISS_EQ = 4'd2,
		ST_UNDEF   = 4'd3,
		ST_KEY     = 4'd4,
		ST_START_V = 4'd5,
		ST_ARRAY   = 4'd6,
		ST_ARR_END = 4'd7,
		ST_END_STR = 4'd8,
		ST_SKIP    = 4'd9,
		ST_INT     = 4'd10,
		ST_REAL    = 4'd11,
		ST_STRING  = 4'd12,
		ST_END_V   = 4'd13,
		ST_START   = 4'd14
	} state_t;

	typedef enum logic [2:0] {
		LS_RUNNING   = 3'd0,
		LS_ACCEPTED  = 3'd1,
		LS_BAD_KEY   = 3'd2,
		LS_BAD_VAL   = 3'd3,
		LS_MISS_EQ   = 3'd4,
		LS_UNDEF     = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		VT_UNDEF  = 2'd0,
		VT_INT    = 2'd1,
		VT_REAL   = 2'd2,
		VT_STRING = 2'd3
	} vtype_t;

	localparam logic [7:0] KEY_LEN_RESET = 8'd128;
	localparam logic [7:0] KEY_CNT_MAX   = 8'd255;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_COMMA  = 8'h2c;
	localparam logic [7:0] CH_DASH   = 8'h2d;
	localparam logic [7:0] CH_DOT    = 8'h2e;
	localparam logic [7:0] CH_EQ     = 8'h3d;
	localparam logic [7:0] CH_LBRACK = 8'h5b;
	localparam logic [7:0] CH_RBRACK = 8'h5d;
	localparam logic [7:0] CH_UNDER  = 8'h5f;

	typedef struct packed {
		state_t      cur;
		state_t      before_skip;
		logic        in_array;
		vtype_t      type_seen;
		logic [7:0]  key_count;
	} ctx_t;

	localparam ctx_t CTX_RESET = '{
		cur:         ST_START,
		before_skip: ST_UNDEF,
		in_array:    1'b0,
		type_seen:   VT_UNDEF,
		key_count:   8'd1
	};

	typedef struct packed {
		state_t      state;
		logic        capture;
		logic        key_char;
		logic        new_element;
		vtype_t      value_type;
		status_t     status;
		logic [7:0]  key_length;
	} res_t;

endpackage
`default_nettype wire

// File: rtl/cll_step.sv
// one lexer step: next context and result for one character
`default_nettype none
module cll_step
	import cll_pkg::*;
(
	input  ctx_t        ctx,
	input  logic [7:0]  ch,
	input  logic        line_start,
	input  logic [7:0]  max_key_length,
	output ctx_t        ctx_next,
	output res_t        res
);

	function automatic logic is_eol(input logic [7:0] c);
		return (c == CH_NUL) || (c == CH_LF);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_key_class(input logic [7:0] c);
		return c inside {[8'h41:8'h5a], [8'h61:8'h7a], CH_DASH, CH_UNDER};
	endfunction

	function automatic state_t after_value(input logic [7:0] c, input logic arr);
		state_t s;
		if (is_eol(c) || (c == CH_HASH && !arr))
			s = ST_END_V;
		else if (c == CH_RBRACK && arr)
			s = ST_ARR_END;
		else if (c == CH_COMMA && arr)
			s = ST_ARRAY;
		else
			s = ST_BAD_VAL;
		return s;
	endfunction

	ctx_t        base;
	state_t      nxt;
	state_t      bs;
	logic        arr;
	logic [7:0]  kc;
	logic [7:0]  kc_inc;
	logic        kfull;
	logic        sp;
	vtype_t      vt;
	logic        cap;
	status_t     st;

	always_comb begin
		base   = line_start ? CTX_RESET : ctx;
		bs     = base.before_skip;
		arr    = base.in_array;
		kc     = base.key_count;
		kc_inc = (base.key_count != KEY_CNT_MAX) ? base.key_count + 8'd1 : base.key_count;
		kfull  = ({1'b0, base.key_count} + 9'd1) > {1'b0, max_key_length};
		sp     = (ch == CH_SPACE);
		nxt    = ST_UNDEF;
		case (base.cur)
			ST_START: begin
				if (sp)
					nxt = ST_START;
				else if (!is_key_class(ch) || kfull)
					nxt = ST_BAD_KEY;
				else begin
					kc  = kc_inc;
					nxt = ST_KEY;
				end
			end
			ST_KEY: begin
				if (sp) begin
					bs  = ST_KEY;
					nxt = ST_SKIP;
				end else if (ch == CH_EQ) begin
					kc  = 8'd0;
					nxt = ST_START_V;
				end else if (is_eol(ch)) begin
					kc  = 8'd0;
					nxt = ST_MISS_EQ;
				end else if (!is_key_class(ch) || kfull)
					nxt = ST_BAD_KEY;
				else begin
					kc  = kc_inc;
					nxt = ST_KEY;
				end
			end
			ST_START_V: begin
				if (sp) begin
					bs  = ST_START_V;
					nxt = ST_SKIP;
				end else if (ch == CH_QUOTE)
					nxt = ST_STRING;
				else if (is_digit(ch))
					nxt = ST_INT;
				else if (is_eol(ch))
					nxt = ST_UNDEF;
				else if (ch == CH_LBRACK) begin
					arr = 1'b1;
					nxt = ST_ARRAY;
				end else
					nxt = ST_BAD_VAL;
			end
			ST_INT, ST_REAL: begin
				if (sp) begin
					bs  = base.cur;
					nxt = ST_SKIP;
				end else if (is_digit(ch))
					nxt = base.cur;
				else if (ch == CH_DOT && base.cur == ST_INT)
					nxt = ST_REAL;
				else
					nxt = after_value(ch, arr);
			end
			ST_STRING: begin
				nxt = (ch == CH_QUOTE) ? ST_END_STR : ST_STRING;
			end
			ST_END_STR: begin
				nxt = sp ? ST_END_STR : after_value(ch, arr);
			end
			ST_ARRAY: begin
				if (sp)
					nxt = ST_ARRAY;
				else if (ch == CH_QUOTE)
					nxt = ST_STRING;
				else if (is_digit(ch))
					nxt = ST_INT;
				else if (is_eol(ch))
					nxt = ST_UNDEF;
				else if (ch == CH_RBRACK)
					nxt = ST_ARR_END;
				else
					nxt = ST_BAD_VAL;
			end
			ST_ARR_END: begin
				if (sp)
					nxt = ST_ARR_END;
				else if (is_eol(ch) || ch == CH_HASH)
					nxt = ST_END_V;
				else
					nxt = ST_BAD_VAL;
			end
			ST_SKIP: begin
				if (sp || ch == CH_TAB)
					nxt = ST_SKIP;
				else if (base.before_skip == ST_KEY)
					nxt = (ch == CH_EQ) ? ST_START_V : ST_BAD_KEY;
				else if (base.before_skip == ST_START_V)
					nxt = ST_START_V;
				else if (base.before_skip == ST_INT || base.before_skip == ST_REAL)
					nxt = after_value(ch, arr);
				else
					nxt = ST_UNDEF;
			end
			ST_BAD_KEY, ST_BAD_VAL, ST_MISS_EQ, ST_END_V: begin
				nxt = base.cur;
			end
			default: begin
				nxt = ST_UNDEF;
			end
		endcase
	end

	always_comb begin
		case (nxt)
			ST_START_V: vt = VT_UNDEF;
			ST_INT:     vt = VT_INT;
			ST_REAL:    vt = VT_REAL;
			ST_STRING:  vt = VT_STRING;
			default:    vt = base.type_seen;
		endcase
		case (nxt)
			ST_END_V:   st = LS_ACCEPTED;
			ST_BAD_KEY: st = LS_BAD_KEY;
			ST_BAD_VAL: st = LS_BAD_VAL;
			ST_MISS_EQ: st = LS_MISS_EQ;
			ST_UNDEF:   st = LS_UNDEF;
			default:    st = LS_RUNNING;
		endcase
		cap = (nxt == ST_INT) || (nxt == ST_REAL) || (nxt == ST_STRING) || (nxt == ST_KEY);
	end

	always_comb begin
		ctx_next.cur         = nxt;
		ctx_next.before_skip = bs;
		ctx_next.in_array    = arr;
		ctx_next.type_seen   = vt;
		ctx_next.key_count   = kc;

		res.state       = nxt;
		res.capture     = cap;
		res.key_char    = cap && (nxt == ST_KEY);
		res.new_element = (nxt == ST_ARRAY) && (base.cur != ST_ARRAY);
		res.value_type  = vt;
		res.status      = st;
		res.key_length  = kc;
	end

endmodule
`default_nettype wire

// File: rtl/config_line_lexer.sv
// config line lexer top level: input register, lexer step, result register
// a character is held in the input register, then its step result in the result register
// throughput: one character per cycle while out_ready does not stall the output
// reset: parse context returns to start state, key limit to 128, both stages empty
// line_start restarts the parse context ahead of that character's step
`default_nettype none
`include "config_line_lexer_defines.svh"
module config_line_lexer
	import cll_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [7:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  ch,
	input  logic        line_start,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  parse_state,
	output logic        capture,
	output logic        key_char,
	output logic        new_element,
	output logic [1:0]  value_type,
	output logic [2:0]  line_status,
	output logic [7:0]  key_length
);

	logic        valid_s1;
	logic [7:0]  ch_s1;
	logic        line_start_s1;
	logic        valid_s2;
	res_t        res_s2;
	ctx_t        ctx_q;
	logic [7:0]  max_key_length_q;
	ctx_t        ctx_next;
	res_t        res_next;
	logic        adv_s1;
	logic        in_beat;

	assign adv_s1   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s1;
	assign in_beat  = in_valid && in_ready;

	cll_step u_step (
		.ctx            (ctx_q),
		.ch             (ch_s1),
		.line_start     (line_start_s1),
		.max_key_length (max_key_length_q),
		.ctx_next       (ctx_next),
		.res            (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1         <= 1'b0;
			valid_s2         <= 1'b0;
			ctx_q            <= CTX_RESET;
			max_key_length_q <= KEY_LEN_RESET;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (!valid_s2 || out_ready)
				valid_s2 <= valid_s1;
			if (adv_s1)
				ctx_q <= ctx_next;
			if (cfg_wen)
				max_key_length_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			ch_s1         <= ch;
			line_start_s1 <= line_start;
		end
		if (adv_s1)
			res_s2 <= res_next;
	end

	assign out_valid   = valid_s2;
	assign parse_state = res_s2.state;
	assign capture     = res_s2.capture;
	assign key_char    = res_s2.key_char;
	assign new_element = res_s2.new_element;
	assign value_type  = res_s2.value_type;
	assign line_status = res_s2.status;
	assign key_length  = res_s2.key_length;

	// error and end states hold until a line start
	`CLL_ASSERT_NEXT(a_sticky, adv_s1 && !line_start_s1 && (ctx_q.cur == ST_BAD_KEY || ctx_q.cur == ST_BAD_VAL || ctx_q.cur == ST_END_V), ctx_q.cur == $past(ctx_q.cur), "error or end state left without line start")
	// context tracks the last delivered beat
	`CLL_ASSERT_NEXT(a_ctx_res, adv_s1, ctx_q.cur == res_s2.state && ctx_q.key_count == res_s2.key_length, "context and result out of step")
	`CLL_ASSERT_IMPL(a_new_elem, out_valid && new_element, parse_state == ST_ARRAY, "new element outside array state")
	`CLL_ASSERT_IMPL(a_stall, !in_ready, valid_s1 && valid_s2 && !out_ready, "input stalled with room free")

endmodule
`default_nettype wire
